// ===== hw/rtl/pgrd_pkg.sv =====
package pgrd_pkg;

  localparam int unsigned ROW_W = 64;
  localparam logic [19:0] RUN_MAX = 20'hFFFFF;
  localparam logic [6:0]  REP_MAX = 7'd127;
  localparam logic [3:0]  LAST_SHORT  = 4'd13;
  localparam logic [3:0]  BITMAP_MODE = 4'd14;
  localparam logic [3:0]  NYB_REPEAT  = 4'd14;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_PACKING = 2'd0;
  localparam logic [1:0] CFG_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_HEIGHT  = 2'd2;
  localparam logic [1:0] CFG_START   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REPEAT2  = 2'd1;
  localparam logic [1:0] ST_EXCESS   = 2'd2;
  localparam logic [1:0] ST_MISMATCH = 2'd3;

  // packed number phases, bit 2 marks a repeat count being read
  localparam logic [1:0] NP_FIRST  = 2'd0;
  localparam logic [1:0] NP_SECOND = 2'd1;
  localparam logic [1:0] NP_ZEROS  = 2'd2;
  localparam logic [1:0] NP_TAIL   = 2'd3;

  typedef enum logic [1:0] {GP_START, GP_DECODE, GP_SKIP} gphase_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_NYB, BK_PAINT, BK_ROW, BK_BIT, BK_END
  } bstate_t;

  typedef struct packed {
    logic [7:0] raster_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [3:0] packing_value;
    logic [6:0] width;
    logic [6:0] height;
    logic       start_black;
  } cfg_t;

  // ones in the k lowest bits
  function automatic logic [ROW_W-1:0] low_mask(input logic [6:0] k);
    logic [ROW_W-1:0] m;
    if (k >= 7'(ROW_W)) m = '1;
    else m = (ROW_W'(1) << k) - ROW_W'(1);
    return m;
  endfunction

endpackage

// ===== hw/rtl/pgrd_front.sv =====
module pgrd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pgrd_pkg::item_t  in_item,
  output logic             q_valid,
  output pgrd_pkg::item_t  q_item,
  input  logic             q_pop
);

  pgrd_pkg::item_t slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rptr_r];

  // store accepted bytes
  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= in_item;
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (q_pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> cnt_r == 2'd2) else $error("full queue lost entry");
`endif

endmodule

// ===== hw/rtl/pgrd_back.sv =====
module pgrd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  pgrd_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  pgrd_pkg::item_t  q_item,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [71:0]      out_tdata,
  output logic [3:0]       out_tuser,
  output logic             out_tlast
);

  pgrd_pkg::bstate_t st_r, st_nxt;
  pgrd_pkg::gphase_t gph_r, gph_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic        nsel_r, nsel_nxt;
  logic [3:0]  bitcnt_r, bitcnt_nxt;
  logic [63:0] rbuf_r, rbuf_nxt;
  logic [6:0]  cols_r, cols_nxt;
  logic [6:0]  rows_r, rows_nxt;
  logic        black_r, black_nxt;
  logic [6:0]  prep_r, prep_nxt;
  logic [2:0]  nph_r, nph_nxt;
  logic [19:0] acc_r, acc_nxt;
  logic [3:0]  zeros_r, zeros_nxt;
  logic [5:0]  ridx_r, ridx_nxt;
  logic [19:0] run_r, run_nxt;
  logic [7:0]  repl_r, repl_nxt;
  logic        retbm_r, retbm_nxt;
  logic        ended_r, ended_nxt;
  logic        cmpl_r, cmpl_nxt;
  logic [1:0]  estat_r, estat_nxt;
  logic        pv_r, pv_nxt;
  logic [5:0]  pidx_r, pidx_nxt;
  logic [63:0] pbits_r, pbits_nxt;
  logic        ov_r, ov_nxt;
  logic [5:0]  oidx_r, oidx_nxt;
  logic [63:0] obits_r, obits_nxt;
  logic [3:0]  ouser_r, ouser_nxt;
  logic        olast_r, olast_nxt;

  logic        out_free;
  logic [3:0]  y, dyn;
  logic        rep;
  logic [23:0] a24;
  logic [19:0] a_sat;
  logic [8:0]  off;
  logic [20:0] v21;
  logic [19:0] v_long, v_second, take_v;
  logic        take;
  logic [6:0]  n, cols_dec;
  logic [63:0] pmask, bmask;
  logic        fin;
  logic [1:0]  fstat;

  assign out_free   = !ov_r || out_tready;
  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, obits_r, oidx_r};
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

  // nybble decode terms
  assign y   = nsel_r ? byte_r[3:0] : byte_r[7:4];
  assign dyn = cfg.packing_value;
  assign rep = nph_r[2];
  assign a24 = {acc_r, y};
  assign a_sat = (a24 > {4'd0, pgrd_pkg::RUN_MAX}) ? pgrd_pkg::RUN_MAX : a24[19:0];
  assign off = {1'b0, pgrd_pkg::LAST_SHORT - dyn, 4'd0} + {5'd0, dyn};
  assign v21 = {1'b0, a_sat} + {12'd0, off};
  always_comb begin
    if (v21 <= 21'd15) v_long = 20'd0;
    else if (v21 - 21'd15 > {1'b0, pgrd_pkg::RUN_MAX}) v_long = pgrd_pkg::RUN_MAX;
    else v_long = 20'(v21 - 21'd15);
  end
  assign v_second = {12'd0, acc_r[3:0], y} + {16'd0, dyn} + 20'd1;

  // run painting terms
  assign n     = (run_r < {13'd0, cols_r}) ? run_r[6:0] : cols_r;
  assign pmask = pgrd_pkg::low_mask(cols_r) & ~pgrd_pkg::low_mask(cols_r - n);
  assign bmask = pgrd_pkg::low_mask(cfg.width);
  assign cols_dec = ((cols_r == 7'd0) ? cfg.width : cols_r) - 7'd1;

  // end-of-byte status
  assign fin = ended_r || last_r;
  always_comb begin
    if (!ended_r) fstat = pgrd_pkg::ST_MISMATCH;
    else if (cmpl_r) fstat = last_r ? pgrd_pkg::ST_OK : pgrd_pkg::ST_MISMATCH;
    else fstat = estat_r;
  end

  // sequencer: next state and datapath updates
  always_comb begin
    st_nxt = st_r;      gph_nxt = gph_r;     byte_nxt = byte_r;  last_nxt = last_r;
    nsel_nxt = nsel_r;  bitcnt_nxt = bitcnt_r; rbuf_nxt = rbuf_r; cols_nxt = cols_r;
    rows_nxt = rows_r;  black_nxt = black_r; prep_nxt = prep_r;  nph_nxt = nph_r;
    acc_nxt = acc_r;    zeros_nxt = zeros_r; ridx_nxt = ridx_r;  run_nxt = run_r;
    repl_nxt = repl_r;  retbm_nxt = retbm_r; ended_nxt = ended_r; cmpl_nxt = cmpl_r;
    estat_nxt = estat_r; pv_nxt = pv_r;      pidx_nxt = pidx_r;  pbits_nxt = pbits_r;
    ov_nxt = ov_r && !out_tready;
    oidx_nxt = oidx_r;  obits_nxt = obits_r; ouser_nxt = ouser_r; olast_nxt = olast_r;
    q_pop = 1'b0;
    take = 1'b0;
    take_v = 20'd0;

    unique case (st_r)
      pgrd_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          byte_nxt = q_item.raster_byte;
          last_nxt = q_item.last_byte;
          ended_nxt = 1'b0;
          cmpl_nxt = 1'b0;
          nsel_nxt = 1'b0;
          bitcnt_nxt = 4'd0;
          if (gph_r == pgrd_pkg::GP_SKIP) begin
            if (q_item.last_byte) gph_nxt = pgrd_pkg::GP_START;
          end else begin
            if (gph_r == pgrd_pkg::GP_START) begin
              rbuf_nxt = '0;
              cols_nxt = cfg.width;
              rows_nxt = cfg.height;
              black_nxt = cfg.start_black;
              prep_nxt = 7'd0;
              nph_nxt = {1'b0, pgrd_pkg::NP_FIRST};
              acc_nxt = 20'd0;
              zeros_nxt = 4'd0;
              ridx_nxt = 6'd0;
              gph_nxt = pgrd_pkg::GP_DECODE;
            end
            st_nxt = (dyn >= pgrd_pkg::BITMAP_MODE) ? pgrd_pkg::BK_BIT : pgrd_pkg::BK_NYB;
          end
        end
      end

      pgrd_pkg::BK_NYB: begin
        unique case (nph_r[1:0])
          pgrd_pkg::NP_FIRST: begin
            if (y == 4'd0) begin
              zeros_nxt = 4'd1;
              nph_nxt = {rep, pgrd_pkg::NP_ZEROS};
            end else if (y <= dyn) begin
              take = 1'b1;
              take_v = {16'd0, y};
            end else if (y <= pgrd_pkg::LAST_SHORT) begin
              acc_nxt = {16'd0, y - dyn - 4'd1};
              nph_nxt = {rep, pgrd_pkg::NP_SECOND};
            end else if (rep || prep_r != 7'd0) begin
              ended_nxt = 1'b1;
              estat_nxt = pgrd_pkg::ST_REPEAT2;
            end else if (y == pgrd_pkg::NYB_REPEAT) begin
              nph_nxt = {1'b1, pgrd_pkg::NP_FIRST};
            end else begin
              prep_nxt = 7'd1;
            end
          end
          pgrd_pkg::NP_SECOND: begin
            take = 1'b1;
            take_v = v_second;
          end
          pgrd_pkg::NP_ZEROS: begin
            if (y == 4'd0) begin
              if (zeros_r < 4'd15) zeros_nxt = zeros_r + 4'd1;
            end else begin
              acc_nxt = {16'd0, y};
              nph_nxt = {rep, pgrd_pkg::NP_TAIL};
            end
          end
          pgrd_pkg::NP_TAIL: begin
            acc_nxt = a_sat;
            if (zeros_r <= 4'd1) begin
              zeros_nxt = 4'd0;
              take = 1'b1;
              take_v = v_long;
            end else begin
              zeros_nxt = zeros_r - 4'd1;
            end
          end
          default: ;
        endcase
        // hand a finished number to the repeat count or the painter
        if (take) begin
          nph_nxt = {1'b0, pgrd_pkg::NP_FIRST};
          if (rep) prep_nxt = (take_v > {13'd0, pgrd_pkg::REP_MAX}) ?
                              pgrd_pkg::REP_MAX : take_v[6:0];
        end
        if (ended_nxt) st_nxt = pgrd_pkg::BK_END;
        else if (take && !rep) begin
          run_nxt = take_v;
          st_nxt = pgrd_pkg::BK_PAINT;
        end else if (!nsel_r) nsel_nxt = 1'b1;
        else st_nxt = pgrd_pkg::BK_END;
      end

      pgrd_pkg::BK_PAINT: begin
        rbuf_nxt = black_r ? (rbuf_r | pmask) : (rbuf_r & ~pmask);
        run_nxt = run_r - {13'd0, n};
        cols_nxt = cols_r - n;
        if (cols_r != n) begin
          black_nxt = ~black_r;
          if (!nsel_r) begin
            nsel_nxt = 1'b1;
            st_nxt = pgrd_pkg::BK_NYB;
          end else st_nxt = pgrd_pkg::BK_END;
        end else begin
          repl_nxt = {1'b0, prep_r} + 8'd1;
          prep_nxt = 7'd0;
          retbm_nxt = 1'b0;
          st_nxt = pgrd_pkg::BK_ROW;
        end
      end

      pgrd_pkg::BK_BIT: begin
        cols_nxt = cols_dec;
        rbuf_nxt[cols_dec[5:0]] = byte_r[3'd7 - bitcnt_r[2:0]];
        bitcnt_nxt = bitcnt_r + 4'd1;
        if (cols_dec == 7'd0) begin
          repl_nxt = {1'b0, prep_r} + 8'd1;
          prep_nxt = 7'd0;
          retbm_nxt = 1'b1;
          st_nxt = pgrd_pkg::BK_ROW;
        end else if (bitcnt_r == 4'd7) st_nxt = pgrd_pkg::BK_END;
      end

      pgrd_pkg::BK_ROW: begin
        if (repl_r == 8'd0) begin
          // row and its repeats are out: clear and resume
          rbuf_nxt = '0;
          cols_nxt = cfg.width;
          if (retbm_r) begin
            if (rows_r == 7'd0) begin
              ended_nxt = 1'b1;
              cmpl_nxt = 1'b1;
              st_nxt = pgrd_pkg::BK_END;
            end else if (bitcnt_r == 4'd8) st_nxt = pgrd_pkg::BK_END;
            else st_nxt = pgrd_pkg::BK_BIT;
          end else if (rows_r == 7'd0) begin
            ended_nxt = 1'b1;
            if (run_r != 20'd0) estat_nxt = pgrd_pkg::ST_EXCESS;
            else cmpl_nxt = 1'b1;
            st_nxt = pgrd_pkg::BK_END;
          end else if (run_r != 20'd0) st_nxt = pgrd_pkg::BK_PAINT;
          else begin
            black_nxt = ~black_r;
            if (!nsel_r) begin
              nsel_nxt = 1'b1;
              st_nxt = pgrd_pkg::BK_NYB;
            end else st_nxt = pgrd_pkg::BK_END;
          end
        end else if (rows_r == 7'd0) begin
          ended_nxt = 1'b1;
          estat_nxt = pgrd_pkg::ST_EXCESS;
          st_nxt = pgrd_pkg::BK_END;
        end else if (!pv_r || out_free) begin
          // hold the new row back until the next result is known
          if (pv_r) begin
            ov_nxt = 1'b1;
            oidx_nxt = pidx_r;
            obits_nxt = pbits_r;
            ouser_nxt = {pgrd_pkg::ST_OK, 1'b0, 1'b1};
            olast_nxt = 1'b0;
          end
          pv_nxt = 1'b1;
          pidx_nxt = ridx_r;
          pbits_nxt = rbuf_r & bmask;
          ridx_nxt = ridx_r + 6'd1;
          rows_nxt = rows_r - 7'd1;
          repl_nxt = repl_r - 8'd1;
        end
      end

      pgrd_pkg::BK_END: begin
        if (!pv_r && !fin) st_nxt = pgrd_pkg::BK_IDLE;
        else if (out_free) begin
          ov_nxt = 1'b1;
          oidx_nxt = pv_r ? pidx_r : 6'd0;
          obits_nxt = pv_r ? pbits_r : 64'd0;
          ouser_nxt = {fin ? fstat : pgrd_pkg::ST_OK, fin, pv_r};
          olast_nxt = 1'b1;
          pv_nxt = 1'b0;
          if (fin) gph_nxt = last_r ? pgrd_pkg::GP_START : pgrd_pkg::GP_SKIP;
          st_nxt = pgrd_pkg::BK_IDLE;
        end
      end

      default: st_nxt = pgrd_pkg::BK_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pgrd_pkg::BK_IDLE;
      gph_r <= pgrd_pkg::GP_START;
      pv_r <= 1'b0;
      ov_r <= 1'b0;
      ended_r <= 1'b0;
      cmpl_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      gph_r <= gph_nxt;
      pv_r <= pv_nxt;
      ov_r <= ov_nxt;
      ended_r <= ended_nxt;
      cmpl_r <= cmpl_nxt;
    end
  end

  // datapath registers, without reset; the glyph fields are loaded at glyph start
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;   last_r <= last_nxt;   nsel_r <= nsel_nxt;
    bitcnt_r <= bitcnt_nxt; rbuf_r <= rbuf_nxt; cols_r <= cols_nxt;
    rows_r <= rows_nxt;   black_r <= black_nxt; prep_r <= prep_nxt;
    nph_r <= nph_nxt;     acc_r <= acc_nxt;     zeros_r <= zeros_nxt;
    ridx_r <= ridx_nxt;   run_r <= run_nxt;     repl_r <= repl_nxt;
    retbm_r <= retbm_nxt; estat_r <= estat_nxt; pidx_r <= pidx_nxt;
    pbits_r <= pbits_nxt; oidx_r <= oidx_nxt;   obits_r <= obits_nxt;
    ouser_r <= ouser_nxt; olast_r <= olast_nxt;
  end

`ifndef SYNTHESIS
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == pgrd_pkg::BK_IDLE |-> !pv_r) else $error("held row left behind");
  a_paint_cols: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == pgrd_pkg::BK_PAINT |-> (cols_r != 7'd0 && cols_r <= 7'd64))
    else $error("painting with no columns");
  a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    gph_r == pgrd_pkg::GP_SKIP |-> st_r != pgrd_pkg::BK_ROW)
    else $error("row emitted while skipping");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == pgrd_pkg::BK_IDLE) else $error("byte taken mid work");
`endif

endmodule

// ===== hw/rtl/pk_glyph_run_length_decoder.sv =====
// Packed-font glyph raster decoder.
// Slave stream: one raster byte per transaction in in_tdata[7:0], in_tlast
// on the final byte of the glyph packet. Bytes go into a two-entry queue.
// Master stream: one pixel row or status per transaction. out_tdata holds
// the row index and the row pixels, out_tuser the row and end flags with
// the status, out_tlast marks the last result caused by one byte.
// Configuration: write packing value, width, height and starting colour on
// cfg_we/cfg_index/cfg_wdata between glyphs; they are read while decoding.
// Sequencing: the decoder works through one nybble or bitmap bit at a
// time, paints each row segment a run crosses, emits each row and closes
// it, besides taking the byte and closing it; a byte that paints a long
// run across many narrow rows keeps it busiest. A new byte is taken only
// once the last one is closed. The newest row waits in a holding register
// until the next result is known.
// Reset clears the queue and the sequencer; the next byte starts a glyph.
// A stalled receiver holds the output register; the decoder waits on it
// while the input queue keeps taking bytes until full.
module pk_glyph_run_length_decoder #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] raster_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [5:0] row_index, [69:6] row_bits, rest zero
  output logic [3:0]  out_tuser,  // [0] row_valid, [1] glyph_end, [3:2] status
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata
);

  logic [3:0] pack_r;
  logic [6:0] width_r, height_r;
  logic       sblack_r;
  pgrd_pkg::cfg_t  cfg;
  pgrd_pkg::item_t in_item, q_item;
  logic q_valid, q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_r <= 4'd0;
      width_r <= 7'd64;
      height_r <= 7'd64;
      sblack_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pgrd_pkg::CFG_PACKING: pack_r <= cfg_wdata[3:0];
        pgrd_pkg::CFG_WIDTH:   width_r <= cfg_wdata;
        pgrd_pkg::CFG_HEIGHT:  height_r <= cfg_wdata;
        pgrd_pkg::CFG_START:   sblack_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clamp sizes to the supported range
  always_comb begin
    cfg.packing_value = pack_r;
    cfg.start_black = sblack_r;
    if (width_r == 7'd0) cfg.width = 7'd1;
    else if (width_r > 7'(MAX_WIDTH)) cfg.width = 7'(MAX_WIDTH);
    else cfg.width = width_r;
    if (height_r == 7'd0) cfg.height = 7'd1;
    else if (height_r > 7'(MAX_HEIGHT)) cfg.height = 7'(MAX_HEIGHT);
    else cfg.height = height_r;
  end

  assign in_item.raster_byte = in_tdata;
  assign in_item.last_byte = in_tlast;

  pgrd_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_item(in_item),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  pgrd_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

endmodule

// ===== sim/pk_glyph_run_length_decoder_test.sv =====
`timescale 1ns / 1ps

module pk_glyph_run_length_decoder_test;

  typedef struct {
    logic [5:0]  row_index;
    logic [63:0] row_bits;
    logic        row_valid;
    logic        glyph_end;
    logic [1:0]  status;
    logic        last_of_item;
  } row_result_t;

  localparam logic [2:0] NP_REPEAT_BIT = 3'd4;
  localparam int unsigned STATUS_DONE = 4;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_wdata;

  pk_glyph_run_length_decoder DUT (.*);

  // predictor copy of registers and state
  logic [3:0]  m_packing;
  logic [6:0]  m_width_reg, m_height_reg;
  logic        m_start_black;
  logic [63:0] m_row;
  int unsigned m_cols, m_rows, m_black, m_repeats, m_nphase, m_accum, m_zeros, m_next_row;
  pgrd_pkg::gphase_t m_gphase;
  bit          m_ended;
  int unsigned m_endstat;

  pgrd_pkg::item_t pending_bytes[$];
  row_result_t expected_rows[$];
  row_result_t step_rows[$];
  int          errors;
  int          hold_off;
  bit          sender_pause;
  int          burst_left, gap_left;

  function automatic int unsigned clamp_size(logic [6:0] v);
    if (v < 1) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  function automatic logic [63:0] ones_below(int unsigned k);
    if (k >= 64) return '1;
    return (64'd1 << k) - 64'd1;
  endfunction

  function automatic void push_row(logic [63:0] bits);
    row_result_t r;
    r.row_index = m_next_row[5:0];
    r.row_bits = bits & ones_below(clamp_size(m_width_reg));
    r.row_valid = 1; r.glyph_end = 0; r.status = pgrd_pkg::ST_OK; r.last_of_item = 0;
    step_rows.push_back(r);
    m_next_row = (m_next_row + 1) % 64;
  endfunction

  function automatic void end_glyph(int unsigned s);
    m_ended = 1;
    m_endstat = s;
  endfunction

  function automatic bit close_row();
    int unsigned r;
    r = m_repeats;
    push_row(m_row);
    m_rows--;
    m_repeats = 0;
    while (r > 0) begin
      if (m_rows == 0) begin
        end_glyph(pgrd_pkg::ST_EXCESS);
        return 0;
      end
      push_row(m_row);
      m_rows--;
      r--;
    end
    m_row = 0;
    m_cols = clamp_size(m_width_reg);
    return 1;
  endfunction

  task automatic paint_run(int unsigned c);
    int unsigned n;
    logic [63:0] m;
    forever begin
      n = c < m_cols ? c : m_cols;
      m = ones_below(m_cols) & ~ones_below(m_cols - n);
      if (m_black != 0) m_row |= m; else m_row &= ~m;
      c -= n;
      m_cols -= n;
      if (m_cols != 0) break;
      if (!close_row()) return;
      if (m_rows == 0) begin
        end_glyph(c > 0 ? pgrd_pkg::ST_EXCESS : STATUS_DONE);
        return;
      end
      if (c == 0) break;
    end
    m_black ^= 1;
  endtask

  task automatic take_number(int unsigned v);
    if ((m_nphase & NP_REPEAT_BIT) != 0) begin
      m_repeats = v > pgrd_pkg::REP_MAX ? pgrd_pkg::REP_MAX : v;
      m_nphase = pgrd_pkg::NP_FIRST;
    end else begin
      m_nphase = pgrd_pkg::NP_FIRST;
      paint_run(v);
    end
  endtask

  task automatic take_nybble(int unsigned y);
    int unsigned dyn, rep, a, v;
    dyn = m_packing;
    rep = m_nphase & NP_REPEAT_BIT;
    case (m_nphase & 3)
      pgrd_pkg::NP_FIRST: begin
        if (y == 0) begin
          m_zeros = 1;
          m_nphase = rep | pgrd_pkg::NP_ZEROS;
        end else if (y <= dyn) begin
          take_number(y);
        end else if (y <= pgrd_pkg::LAST_SHORT) begin
          m_accum = y - dyn - 1;
          m_nphase = rep | pgrd_pkg::NP_SECOND;
        end else begin
          if (rep != 0 || m_repeats != 0) begin
            end_glyph(pgrd_pkg::ST_REPEAT2);
            return;
          end
          if (y == pgrd_pkg::NYB_REPEAT) m_nphase = NP_REPEAT_BIT;
          else m_repeats = 1;
        end
      end
      pgrd_pkg::NP_SECOND: take_number(m_accum * 16 + y + dyn + 1);
      pgrd_pkg::NP_ZEROS: begin
        if (y == 0) begin
          if (m_zeros < 15) m_zeros++;
        end else begin
          m_accum = y;
          m_nphase = rep | pgrd_pkg::NP_TAIL;
        end
      end
      default: begin
        a = m_accum * 16 + y;
        if (a > pgrd_pkg::RUN_MAX) a = pgrd_pkg::RUN_MAX;
        m_accum = a;
        if (m_zeros <= 1) begin
          m_zeros = 0;
          v = a + (pgrd_pkg::LAST_SHORT - dyn) * 16 + dyn;
          v = v > 15 ? v - 15 : 0;
          if (v > pgrd_pkg::RUN_MAX) v = pgrd_pkg::RUN_MAX;
          take_number(v);
        end else begin
          m_zeros--;
        end
      end
    endcase
  endtask

  task automatic bitmap_byte(logic [7:0] b);
    for (int i = 0; i < 8; i++) begin
      if (m_cols == 0) m_cols = clamp_size(m_width_reg);
      m_cols--;
      if (b[7-i]) m_row[m_cols] = 1'b1; else m_row[m_cols] = 1'b0;
      if (m_cols == 0) begin
        void'(close_row());
        if (m_rows == 0) begin
          end_glyph(STATUS_DONE);
          return;
        end
      end
    end
  endtask

  task automatic predictor_reset();
    m_packing = 0; m_width_reg = 64; m_height_reg = 64; m_start_black = 0;
    m_gphase = pgrd_pkg::GP_START;
  endtask

  // work out the rows one raster byte causes
  task automatic predict_byte(pgrd_pkg::item_t it);
    row_result_t r;
    step_rows.delete();
    m_ended = 0;
    m_endstat = 0;
    if (m_gphase == pgrd_pkg::GP_SKIP) begin
      if (it.last_byte) m_gphase = pgrd_pkg::GP_START;
      return;
    end
    if (m_gphase != pgrd_pkg::GP_DECODE) begin
      m_row = 0; m_cols = clamp_size(m_width_reg); m_rows = clamp_size(m_height_reg);
      m_black = m_start_black; m_repeats = 0; m_nphase = pgrd_pkg::NP_FIRST; m_accum = 0;
      m_zeros = 0; m_next_row = 0; m_gphase = pgrd_pkg::GP_DECODE;
    end
    if (m_packing >= pgrd_pkg::BITMAP_MODE) begin
      bitmap_byte(it.raster_byte);
    end else begin
      take_nybble(it.raster_byte[7:4]);
      if (!m_ended) take_nybble(it.raster_byte[3:0]);
    end
    if (!m_ended && it.last_byte) end_glyph(pgrd_pkg::ST_MISMATCH);
    if (m_ended) begin
      if (m_endstat == STATUS_DONE)
        m_endstat = it.last_byte ? pgrd_pkg::ST_OK : pgrd_pkg::ST_MISMATCH;
      m_gphase = it.last_byte ? pgrd_pkg::GP_START : pgrd_pkg::GP_SKIP;
      if (step_rows.size() == 0) begin
        r.row_index = 0; r.row_bits = 0; r.row_valid = 0;
        r.glyph_end = 0; r.status = pgrd_pkg::ST_OK; r.last_of_item = 0;
        step_rows.push_back(r);
      end
      step_rows[$].glyph_end = 1;
      step_rows[$].status = m_endstat[1:0];
    end
    if (step_rows.size() > 0) step_rows[$].last_of_item = 1;
    foreach (step_rows[i]) expected_rows.push_back(step_rows[i]);
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_byte(pending_bytes.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered transaction
      end else if (pending_bytes.size() == 0 || sender_pause) begin
        in_tvalid <= 0;
      end else if (gap_left > 0) begin
        in_tvalid <= 0;
        gap_left <= gap_left - 1;
      end else begin
        in_tvalid <= 1;
        in_tdata <= pending_bytes[0].raster_byte;
        in_tlast <= pending_bytes[0].last_byte;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // monitor: stall pattern, long hold-off on request, compare fields
  always @(posedge clk) begin
    row_result_t e;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_rows.size() == 0) begin
          $display("%0t unexpected result tdata=%h tuser=%h", $time, out_tdata, out_tuser);
          errors++;
        end else begin
          e = expected_rows.pop_front();
          if (out_tdata[5:0] !== e.row_index || out_tdata[69:6] !== e.row_bits ||
              out_tdata[71:70] !== 2'b00 || out_tuser[0] !== e.row_valid ||
              out_tuser[1] !== e.glyph_end || out_tuser[3:2] !== e.status ||
              out_tlast !== e.last_of_item) begin
            $display("%0t mismatch expected idx=%0d bits=%h v=%b end=%b st=%0d last=%b",
                     $time, e.row_index, e.row_bits, e.row_valid, e.glyph_end,
                     e.status, e.last_of_item);
            $display("%0t          actual   idx=%0d bits=%h v=%b end=%b st=%0d last=%b",
                     $time, out_tdata[5:0], out_tdata[69:6], out_tuser[0], out_tuser[1],
                     out_tuser[3:2], out_tlast);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_tready <= 0;
      end else begin
        case ($time / 4000 % 3)
          0: out_tready <= 1;
          1: out_tready <= $urandom_range(0, 3) != 0;
          default: out_tready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [6:0] v);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      pgrd_pkg::CFG_PACKING: m_packing = v[3:0];
      pgrd_pkg::CFG_WIDTH:   m_width_reg = v;
      pgrd_pkg::CFG_HEIGHT:  m_height_reg = v;
      default:               m_start_black = v[0];
    endcase
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_tvalid || expected_rows.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic add_byte(logic [7:0] b, logic l);
    pgrd_pkg::item_t it;
    it.raster_byte = b;
    it.last_byte = l;
    pending_bytes.push_back(it);
  endtask

  // random glyph bytes: bitmap bytes, or packed nybbles with some repeat codes
  task automatic add_glyph(int unsigned nbytes, bit bitmap);
    for (int i = 0; i < nbytes; i++) begin
      if (bitmap) add_byte(8'($urandom_range(0, 255)), i == nbytes - 1);
      else if ($urandom_range(0, 9) == 0) add_byte({4'hE, 4'($urandom_range(1, 3))},
                                                  i == nbytes - 1);
      else add_byte({4'($urandom_range(1, 13)), 4'($urandom_range(0, 13))},
                    i == nbytes - 1);
    end
  endtask

  int total;

  initial begin
    errors = 0; hold_off = 0; sender_pause = 0;
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tlast = 0;
    out_tready = 0; cfg_we = 0; cfg_index = pgrd_pkg::CFG_PACKING; cfg_wdata = 0;
    predictor_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed: bitmap extremes, zero sizes clamped to one
    cfg_write(pgrd_pkg::CFG_PACKING, 7'd14);
    cfg_write(pgrd_pkg::CFG_WIDTH, 7'd1);
    cfg_write(pgrd_pkg::CFG_HEIGHT, 7'd3);
    cfg_write(pgrd_pkg::CFG_START, 7'd1);
    add_byte(8'hA0, 1);
    add_byte(8'hFF, 0); add_byte(8'h00, 1);
    drain();
    cfg_write(pgrd_pkg::CFG_PACKING, 7'd15);
    cfg_write(pgrd_pkg::CFG_WIDTH, 7'd0);
    cfg_write(pgrd_pkg::CFG_HEIGHT, 7'd0);
    add_byte(8'h80, 0); add_byte(8'h55, 1);
    drain();
    // packed: every form, repeat codes, second repeat, long prefix, excess
    cfg_write(pgrd_pkg::CFG_PACKING, 7'd0);
    cfg_write(pgrd_pkg::CFG_WIDTH, 7'd100);
    cfg_write(pgrd_pkg::CFG_HEIGHT, 7'd127);
    cfg_write(pgrd_pkg::CFG_START, 7'd0);
    add_byte(8'h00, 0); add_byte(8'h00, 0); add_byte(8'h00, 0);
    add_byte(8'h00, 0); add_byte(8'h00, 0); add_byte(8'h00, 0);
    add_byte(8'h00, 0); add_byte(8'h00, 0); add_byte(8'h1F, 0);
    add_byte(8'hFF, 0); add_byte(8'hFF, 0); add_byte(8'hFF, 0);
    add_byte(8'hFF, 0); add_byte(8'hFF, 0); add_byte(8'hFF, 0);
    add_byte(8'hFF, 1);
    add_byte(8'hEE, 0); add_byte(8'h12, 1);
    add_byte(8'hF1, 0); add_byte(8'hF3, 1);
    drain();
    cfg_write(pgrd_pkg::CFG_PACKING, 7'd13);
    cfg_write(pgrd_pkg::CFG_WIDTH, 7'd8);
    cfg_write(pgrd_pkg::CFG_HEIGHT, 7'd2);
    add_byte(8'hE0, 0); add_byte(8'h2F, 0); add_byte(8'h18, 1);
    add_byte(8'hDD, 1);
    add_byte(8'h8F, 0); add_byte(8'h88, 0); add_byte(8'h12, 1);
    drain();

    // random phases over several settings
    total = 0;
    for (int ph = 0; total < 370; ph++) begin
      bit bm;
      int unsigned w, h;
      bm = $urandom_range(0, 3) == 0;
      w = (ph % 5 == 0) ? 64 : $urandom_range(1, 16);
      h = (ph % 5 == 1) ? 64 : $urandom_range(1, 8);
      cfg_write(pgrd_pkg::CFG_PACKING, bm ? 7'd14 : 7'($urandom_range(0, 13)));
      cfg_write(pgrd_pkg::CFG_WIDTH, 7'(w));
      cfg_write(pgrd_pkg::CFG_HEIGHT, 7'(h));
      cfg_write(pgrd_pkg::CFG_START, 7'($urandom_range(0, 1)));
      for (int g = 0; g < 4; g++) begin
        int unsigned n;
        n = bm ? (w * h + 7) / 8 + $urandom_range(0, 2) - 1 : $urandom_range(1, 10);
        if (n < 1) n = 1;
        if ($urandom_range(0, 7) == 0)
          for (int k = 0; k < 3; k++) add_byte(8'($urandom_range(0, 255)), k == 2);
        else add_glyph(n, bm);
        total += n;
      end
      if (ph == 2) begin
        hold_off = 400;
      end
      if (ph == 4) begin
        sender_pause = 1;
        while (expected_rows.size() != 0 || in_tvalid) @(posedge clk);
        sender_pause = 0;
      end
      drain();
    end

    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== pk_glyph_run_length_decoder.f =====
hw/rtl/pgrd_pkg.sv
hw/rtl/pgrd_front.sv
hw/rtl/pgrd_back.sv
hw/rtl/pk_glyph_run_length_decoder.sv
sim/pk_glyph_run_length_decoder_test.sv
